@@ src/brb_pkg.sv @@
package brb_pkg;

  // default ring depth in bytes, a power of two
  localparam int unsigned RingSizeDefault = 1024;

  // request codes
  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_READ    = 3'd1;
  localparam logic [2:0] REQ_DISCARD = 3'd2;
  localparam logic [2:0] REQ_STATUS  = 3'd3;
  localparam logic [2:0] REQ_RESET   = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [10:0] length;
    logic [9:0]  offset;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  read_byte;
    logic [10:0] granted;
    logic [10:0] used_count;
    logic [10:0] free_count;
    logic [10:0] contiguous_count;
    logic [9:0]  tail_index;
  } rsp_t;

  // memory port controls from the pointer logic
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

@@ src/brb_if.sv @@
interface brb_req_if;
  import brb_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brb_rsp_if;
  import brb_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/brb_ram.sv @@
module brb_ram #(
  parameter int unsigned RingSize = brb_pkg::RingSizeDefault
) (
  input  logic                        clk_i,
  input  brb_pkg::mem_ctl_t           ctl_i,
  input  logic [$clog2(RingSize)-1:0] addr_i,
  input  logic [7:0]                  wdata_i,
  output logic [7:0]                  rdata_o
);
  import brb_pkg::*;

  logic [7:0] mem_q [RingSize];
  logic [7:0] rdata_q;

  // single port byte store, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/brb_ctrl.sv @@
module brb_ctrl #(
  parameter int unsigned RingSize = brb_pkg::RingSizeDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  brb_req_if.sink                     req,
  input  logic                        rsp_ready_i,
  output logic                        rsp_valid_o,
  output brb_pkg::rsp_t               rsp_o,
  output logic                        rsp_rd_o,
  output brb_pkg::mem_ctl_t           mem_ctl_o,
  output logic [$clog2(RingSize)-1:0] mem_addr_o,
  output logic [7:0]                  mem_wdata_o
);
  import brb_pkg::*;

  localparam int unsigned IdxW = $clog2(RingSize);
  localparam int unsigned PtrW = IdxW + 1;
  localparam int unsigned CntW = (PtrW > 11) ? PtrW : 11;

  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic            vld_q;
  logic            rd_q;
  rsp_t            rsp_q, rsp_d;

  logic            accept;
  logic [CntW-1:0] used_w, free_w, len_w, off_w, grant_w;
  logic [CntW-1:0] used_n, contig_n;
  logic [IdxW-1:0] tidx_n;
  logic [PtrW-1:0] wr_ptr, rd_ptr, used_p;
  logic            wr_ok, rd_ok, dis_ok;

  assign req.ready = !vld_q || rsp_ready_i;
  assign accept    = req.valid && req.ready;

  // occupancy before this transaction
  assign used_w = CntW'(head_q - tail_q);
  assign free_w = CntW'(RingSize) - used_w;
  assign len_w  = CntW'(req.data.length);
  assign off_w  = CntW'(req.data.offset);
  assign grant_w = (len_w < used_w) ? len_w : used_w;

  assign wr_ok  = (len_w != '0) && (len_w <= free_w) && (off_w < len_w);
  assign rd_ok  = off_w < grant_w;
  assign dis_ok = (len_w != '0) && (len_w <= used_w);

  assign wr_ptr = head_q + PtrW'(req.data.offset);
  assign rd_ptr = tail_q + PtrW'(req.data.offset);

  // request decode and pointer update
  always_comb begin
    head_d            = head_q;
    tail_d            = tail_q;
    rsp_d             = '0;
    mem_ctl_o         = '0;
    mem_addr_o        = rd_ptr[IdxW-1:0];
    unique case (req.data.req_type)
      REQ_WRITE: begin
        mem_addr_o = wr_ptr[IdxW-1:0];
        if (wr_ok) begin
          rsp_d.ok     = 1'b1;
          mem_ctl_o.we = accept;
          if (off_w == len_w - CntW'(1)) begin
            head_d = head_q + PtrW'(len_w);
          end
        end
      end
      REQ_READ: begin
        rsp_d.granted = 11'(grant_w);
        if (rd_ok) begin
          rsp_d.ok     = 1'b1;
          mem_ctl_o.re = accept;
        end
      end
      REQ_DISCARD: begin
        if (dis_ok) begin
          rsp_d.ok = 1'b1;
          tail_d   = tail_q + PtrW'(len_w);
        end
      end
      REQ_STATUS: begin
        rsp_d.ok = 1'b1;
      end
      REQ_RESET: begin
        rsp_d.ok = 1'b1;
        head_d   = '0;
        tail_d   = '0;
      end
      default: begin
      end
    endcase

    // status after this transaction
    rsp_d.used_count       = 11'(used_n);
    rsp_d.free_count       = 11'(CntW'(RingSize) - used_n);
    rsp_d.contiguous_count = 11'(contig_n);
    rsp_d.tail_index       = 10'(CntW'(tidx_n));
  end

  assign mem_wdata_o = req.data.data_byte;

  assign used_p   = head_d - tail_d;
  assign used_n   = CntW'(used_p);
  assign tidx_n   = tail_d[IdxW-1:0];
  assign contig_n = (used_n == '0) ? '0 :
                    ((CntW'(RingSize) - CntW'(tidx_n) > used_n) ? used_n :
                     CntW'(RingSize) - CntW'(tidx_n));

  // pointers and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (accept) begin
        head_q <= head_d;
        tail_q <= tail_d;
        vld_q  <= 1'b1;
      end else if (rsp_ready_i) begin
        vld_q  <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
      rd_q  <= (req.data.req_type == REQ_READ) && rd_ok;
    end
  end

  assign rsp_valid_o = vld_q;
  assign rsp_o       = rsp_q;
  assign rsp_rd_o    = rd_q;

endmodule

@@ src/byte_ring_buffer.sv @@
// byte_ring_buffer: power-of-two byte ring with free-running head and tail pointers
// an accepted request's response is on rsp_o in the next cycle, one request per
// cycle while rsp_o.ready is high or no response is held; each request makes at
// most one access to the single-port byte store, with read data the cycle after
// reset: rst_ni clears head, tail and the response valid; no clearing pass
module byte_ring_buffer #(
  parameter int unsigned RingSize = brb_pkg::RingSizeDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  brb_req_if.sink   req_i,
  brb_rsp_if.source rsp_o
);
  import brb_pkg::*;

  localparam int unsigned IdxW = $clog2(RingSize);

  mem_ctl_t        mem_ctl;
  logic [IdxW-1:0] mem_addr;
  logic [7:0]      mem_wdata;
  logic [7:0]      mem_rdata;
  rsp_t            rsp_base;
  logic            rsp_rd;

  // pointer logic and response register
  brb_ctrl #(
    .RingSize (RingSize)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_o       (rsp_base),
    .rsp_rd_o    (rsp_rd),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata)
  );

  // byte store
  brb_ram #(
    .RingSize (RingSize)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // merge the read byte into the response
  always_comb begin
    rsp_o.data           = rsp_base;
    rsp_o.data.read_byte = rsp_rd ? mem_rdata : 8'd0;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import brb_pkg::*;

  localparam int unsigned RING_SIZE = RingSizeDefault;
  localparam logic [10:0] RING_W = 11'(RING_SIZE);
  localparam int unsigned ITEM_TARGET = 1125;
  localparam int unsigned DRAIN_CYCLES = 10;

  // ways to split one write transaction into byte items
  typedef enum int unsigned {
    TXN_IN_ORDER,
    TXN_SHUFFLED,
    TXN_SPARSE,
    TXN_LAST_ONLY,
    TXN_STRAY
  } txn_style_e;

  // pointers, byte store, and which entries were ever written since power-up
  typedef struct packed {
    logic [10:0]            head;
    logic [10:0]            tail;
    logic [RING_SIZE-1:0]   filled;
    logic [8*RING_SIZE-1:0] bytes;
  } ring_state_t;

  logic clk_i;
  logic rst_ni;

  brb_req_if req_if ();
  brb_rsp_if rsp_if ();

  byte_ring_buffer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ring_state_t plan_ring = '0;  // ring as the stimulus will leave it
  ring_state_t live_ring = '0;  // ring as of the last accepted request
  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  int unsigned req_count = 0;
  int unsigned err_cnt = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  logic        calm = 1'b0;

  function automatic logic [10:0] min11(input logic [10:0] a, input logic [10:0] b);
    return (a < b) ? a : b;
  endfunction

  // response of the ring to one request, updating its state
  function automatic rsp_t ring_step(inout ring_state_t st, input req_t rq);
    logic [10:0] used;
    logic [10:0] room;
    logic [9:0]  slot;
    rsp_t        rs;
    rs   = '0;
    used = st.head - st.tail;
    room = RING_W - used;
    case (rq.req_type)
      REQ_WRITE: begin
        if (rq.length != '0 && rq.length <= room && rq.offset < rq.length) begin
          slot = st.head[9:0] + rq.offset;
          st.bytes[slot*8 +: 8] = rq.data_byte;
          st.filled[slot] = 1'b1;
          if (rq.offset == rq.length - 11'd1) st.head = st.head + rq.length;
          rs.ok = 1'b1;
        end
      end
      REQ_READ: begin
        rs.granted = min11(rq.length, used);
        if (rq.offset < rs.granted) begin
          slot = st.tail[9:0] + rq.offset;
          rs.read_byte = st.bytes[slot*8 +: 8];
          rs.ok = 1'b1;
        end
      end
      REQ_DISCARD: begin
        if (rq.length != '0 && rq.length <= used) begin
          st.tail = st.tail + rq.length;
          rs.ok = 1'b1;
        end
      end
      REQ_STATUS: rs.ok = 1'b1;
      REQ_RESET: begin
        st.head = '0;
        st.tail = '0;
        rs.ok = 1'b1;
      end
      default: ;
    endcase
    used = st.head - st.tail;
    rs.used_count = used;
    rs.free_count = RING_W - used;
    rs.tail_index = st.tail[9:0];
    if (used == '0) rs.contiguous_count = '0;
    else rs.contiguous_count = min11(RING_W - {1'b0, st.tail[9:0]}, used);
    return rs;
  endfunction

  // idle length for either side: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // queue one request; a read that would hit a never-written entry is redirected
  task automatic queue_req(input logic [2:0] kind, input logic [10:0] len,
                           input logic [9:0] off, input logic [7:0] value);
    req_t        rq;
    logic [10:0] used;
    logic [10:0] grant;
    logic [9:0]  slot;
    int unsigned tries;
    rq = '{req_type: kind, length: len, offset: off, data_byte: value};
    if (kind == REQ_READ) begin
      used  = plan_ring.head - plan_ring.tail;
      grant = min11(len, used);
      if (rq.offset < grant) begin
        tries = 0;
        slot  = plan_ring.tail[9:0] + rq.offset;
        while (!plan_ring.filled[slot] && tries < 16) begin
          rq.offset = 10'($urandom_range(0, grant - 11'd1));
          slot = plan_ring.tail[9:0] + rq.offset;
          tries++;
        end
        if (!plan_ring.filled[slot]) begin
          if (grant < RING_W) rq.offset = grant[9:0];
          else rq.length = '0;
        end
      end
    end
    pending_reqs.push_back(rq);
    void'(ring_step(plan_ring, rq));
    if (kind <= REQ_RESET) req_count++;
  endtask

  // split a write transaction into byte items
  task automatic queue_write_txn(input logic [10:0] len, input txn_style_e style);
    int unsigned order[$];
    int unsigned j;
    int unsigned tmp;
    for (int unsigned i = 0; i < len; i++) begin
      if (style == TXN_LAST_ONLY && i != len - 1) continue;
      if (style == TXN_SPARSE && i != len - 1 && $urandom_range(0, 1) == 0) continue;
      order.push_back(i);
    end
    if (style == TXN_SHUFFLED) begin
      for (int unsigned i = order.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    if (style == TXN_STRAY && len < RING_W)
      order.insert($urandom_range(0, order.size()), $urandom_range(len, RING_SIZE - 1));
    foreach (order[k])
      queue_req(REQ_WRITE, len, 10'(order[k]), 8'($urandom_range(0, 255)));
  endtask

  // field compare against the prediction
  task automatic check_field(input string name, input logic [10:0] want,
                             input logic [10:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // request driver: predict on acceptance, then present the next pending item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        expected_rsps.push_back(ring_step(live_ring, req_if.data));
      if (!req_if.valid || req_if.ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_if.data <= pending_reqs.pop_front();
          req_if.valid <= 1'b1;
          send_wait <= idle_len();
          if ($urandom_range(0, 63) == 0) calm <= ~calm;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor with random back-pressure
  always @(posedge clk_i) begin : rsp_monitor
    rsp_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response transaction with no request outstanding");
          err_cnt++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("ok", want.ok, rsp_if.data.ok);
          check_field("read_byte", want.read_byte, rsp_if.data.read_byte);
          check_field("granted", want.granted, rsp_if.data.granted);
          check_field("used_count", want.used_count, rsp_if.data.used_count);
          check_field("free_count", want.free_count, rsp_if.data.free_count);
          check_field("contiguous_count", want.contiguous_count,
                      rsp_if.data.contiguous_count);
          check_field("tail_index", want.tail_index, rsp_if.data.tail_index);
        end
      end
      if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        recv_wait <= idle_len();
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    logic [10:0] used;
    logic [10:0] room;
    logic [10:0] len;
    logic [10:0] grant;
    logic [9:0]  off;
    int unsigned pick;
    int unsigned r;
    txn_style_e  style;

    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;

    // directed: empty ring, bad lengths, grants, full ring, wrap, reset request
    queue_req(REQ_STATUS, 11'd0, 10'd0, 8'h00);
    queue_req(REQ_READ, 11'd5, 10'd0, 8'h00);      // nothing to grant
    queue_req(REQ_DISCARD, 11'd1, 10'd0, 8'h00);   // discard on empty
    queue_req(REQ_WRITE, 11'd0, 10'd0, 8'hFF);     // zero length
    queue_req(REQ_WRITE, 11'd3, 10'd3, 8'hFF);     // offset past length
    queue_req(REQ_WRITE, 11'd3, 10'd0, 8'h00);
    queue_req(REQ_WRITE, 11'd3, 10'd1, 8'hFF);
    queue_req(REQ_WRITE, 11'd3, 10'd2, 8'hA5);
    queue_req(REQ_READ, RING_W, 10'd2, 8'h00);     // grant clipped to used
    queue_req(REQ_READ, 11'd2, 10'd2, 8'h00);      // outside grant
    queue_req(REQ_READ, 11'd0, 10'd0, 8'h00);
    queue_req(REQ_DISCARD, 11'd4, 10'd0, 8'h00);   // more than used
    queue_req(REQ_DISCARD, 11'd3, 10'd0, 8'h00);
    queue_req(REQ_WRITE, RING_W, 10'd1023, 8'h5A); // whole ring, last byte only
    queue_req(REQ_WRITE, 11'd1, 10'd0, 8'h77);     // no room left
    queue_req(REQ_READ, RING_W, 10'd1023, 8'h00);
    queue_req(REQ_STATUS, 11'd0, 10'd0, 8'h00);
    queue_req(REQ_DISCARD, RING_W, 10'd0, 8'h00);
    queue_req(REQ_RESET + 3'd1, 11'd7, 10'd1, 8'h03);
    queue_req(REQ_RESET + 3'd3, RING_W, 10'd1023, 8'hFF);
    queue_req(REQ_RESET, 11'd0, 10'd0, 8'h00);
    queue_req(REQ_WRITE, 11'd2, 10'd1, 8'h11);     // out-of-order offsets
    queue_req(REQ_WRITE, 11'd2, 10'd0, 8'h22);
    queue_req(REQ_READ, 11'd2, 10'd1, 8'h00);
    queue_req(REQ_DISCARD, 11'd2, 10'd0, 8'h00);
    queue_req(REQ_WRITE, 11'd2, 10'd1, 8'h33);     // first byte left unstaged
    queue_req(REQ_READ, 11'd2, 10'd0, 8'h00);      // old content of that entry

    // random traffic, mostly well-formed transactions
    while (req_count < ITEM_TARGET) begin
      used = plan_ring.head - plan_ring.tail;
      room = RING_W - used;
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
        if (room == '0) len = 11'($urandom_range(1, 8));
        else if ($urandom_range(0, 15) == 0) len = min11(room, 11'd64);
        else len = 11'($urandom_range(1, min11(room, 11'd16)));
        r = $urandom_range(0, 9);
        if (r < 6) style = TXN_IN_ORDER;
        else if (r < 8) style = TXN_SHUFFLED;
        else if (r < 9) style = TXN_SPARSE;
        else style = TXN_STRAY;
        queue_write_txn(len, style);
      end else if (pick < 44) begin
        // pointer jump: only the closing byte of a long transaction
        if (room == '0) len = 11'($urandom_range(1, RING_SIZE));
        else if ($urandom_range(0, 3) == 0) len = room;
        else len = 11'($urandom_range(1, room));
        queue_write_txn(len, TXN_LAST_ONLY);
      end else if (pick < 64) begin
        repeat ($urandom_range(1, 6)) begin
          r = $urandom_range(0, 7);
          if (r == 0) len = RING_W;
          else if (r == 1) len = '0;
          else len = 11'($urandom_range(1, min11(used + 11'd4, RING_W)));
          grant = min11(len, used);
          if (grant != '0 && $urandom_range(0, 5) != 0)
            off = 10'($urandom_range(0, grant - 11'd1));
          else
            off = 10'($urandom_range(0, RING_SIZE - 1));
          queue_req(REQ_READ, len, off, 8'($urandom_range(0, 255)));
        end
      end else if (pick < 80) begin
        r = $urandom_range(0, 5);
        if (r == 0)
          len = (used < RING_W) ? min11(used + 11'($urandom_range(1, 4)), RING_W) : '0;
        else if (r == 1) len = used;
        else if (r == 2) len = (used != '0) ? 11'($urandom_range(1, used)) : '0;
        else len = (used != '0) ? 11'($urandom_range(1, min11(used, 11'd32))) : 11'd1;
        queue_req(REQ_DISCARD, len, 10'($urandom_range(0, 1023)),
                  8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        queue_req(REQ_STATUS, 11'($urandom_range(0, RING_SIZE)),
                  10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        queue_req(3'(REQ_RESET + $urandom_range(1, 3)), 11'($urandom_range(0, RING_SIZE)),
                  10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        queue_req(REQ_RESET, 11'($urandom_range(0, RING_SIZE)),
                  10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
      end else begin
        // malformed write byte
        r = $urandom_range(0, 2);
        if (r == 0) begin
          len = '0;
          off = 10'($urandom_range(0, 1023));
        end else if (r == 1 && room < RING_W) begin
          len = 11'($urandom_range(room + 11'd1, RING_SIZE));
          off = 10'($urandom_range(0, len - 11'd1));
        end else begin
          len = 11'($urandom_range(1, RING_SIZE - 1));
          off = 10'($urandom_range(len, RING_SIZE - 1));
        end
        queue_req(REQ_WRITE, len, off, 8'($urandom_range(0, 255)));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ byte_ring_buffer.f @@
src/brb_pkg.sv
src/brb_if.sv
src/brb_ram.sv
src/brb_ctrl.sv
src/byte_ring_buffer.sv
tb/tb_top.sv
